@@ rtl/core/otau_pkg.sv @@
// Package: shared widths, payload types and the pipe segment table.
package otau_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned PIPE_W  = 3;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned DIGITS  = 6;
  localparam int unsigned RPA_W   = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] other_address;
    logic [PIPE_W-1:0] pipe;
  } in_t;

  typedef struct packed {
    logic               address_valid;
    logic               is_descendant;
    logic               is_child;
    logic [ADDR_W-1:0]  next_hop;
    logic [PIPE_W-1:0]  pipe_of_address;
    logic [ADDR_W-1:0]  address_for_pipe;
    logic [RPA_W-1:0]   radio_pipe_address;
    logic [LEVEL_W-1:0] tree_level;
    logic [ADDR_W-1:0]  parent_address;
    logic [PIPE_W-1:0]  uplink_pipe;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  own;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  deep_mask;
    logic [ADDR_W-1:0]  nhop_mask;
    logic [SHIFT_W-1:0] shift;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  parent;
    logic [PIPE_W-1:0]  ppipe;
  } own_cfg_t;

  typedef struct packed {
    logic [DIGITS-1:0]  bad;
    logic [ADDR_W-1:0]  masked;
    logic [ADDR_W-1:0]  high;
    logic [ADDR_W-1:0]  next_hop;
    logic [PIPE_W-1:0]  pipe_of_address;
    logic [ADDR_W-1:0]  address_for_pipe;
    logic [RPA_W-1:0]   radio_pipe_address;
  } mid_t;

  function automatic logic [7:0] pipe_segment(input logic [PIPE_W-1:0] pipe);
    logic [7:0] seg;
    case (pipe)
      3'd0:    seg = 8'h3c;
      3'd1:    seg = 8'h5a;
      3'd2:    seg = 8'h69;
      3'd3:    seg = 8'h96;
      3'd4:    seg = 8'ha5;
      3'd5:    seg = 8'hc3;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/core/otau_stream_if.sv @@
// Interface: valid/ready stream channel with a typed payload.
interface otau_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/octal_tree_address_unit.sv @@
// Top level: octal tree address classification and routing pipeline.
// Pipeline: 3 register stages (input, digit, result), passed in that order.
// Throughput: one item per cycle; each register stage holds under backpressure.
// An own address write is registered, then decoded into a registered level and masks.
// Reset: asynchronous, active low; clears all valid bits and sets own address to 0.
module octal_tree_address_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [otau_pkg::ADDR_W-1:0]   cfg_wdata_i,
  otau_stream_if.sink                   in_i,
  otau_stream_if.source                 out_o
);
  import otau_pkg::*;

  own_cfg_t cfg;
  logic     s1_valid_q;
  in_t      s1_q;
  logic     s1_ready;
  logic     s2_valid;
  logic     s2_ready;
  mid_t     s2_data;
  out_t     res;

  otau_own_decode u_own (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_i.ready = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.payload;
    end
  end

  otau_digit_stage u_digit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid_q),
    .ready_o (s1_ready),
    .data_i  (s1_q),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  otau_class_stage u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.payload = res;
endmodule

@@ rtl/core/otau_own_decode.sv @@
// Own address register and its registered level, mask and parent decode.
module otau_own_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [otau_pkg::ADDR_W-1:0]   cfg_wdata_i,
  output otau_pkg::own_cfg_t            cfg_o
);
  import otau_pkg::*;

  logic [ADDR_W-1:0] own_q;
  own_cfg_t          cfg_d, cfg_q;

  function automatic own_cfg_t decode_own(input logic [ADDR_W-1:0] own);
    own_cfg_t          c;
    logic [18:0]       m19;
    logic [ADDR_W-1:0] up;
    logic [LEVEL_W-1:0] lv;
    lv = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if ((own >> (3 * i)) != '0) lv = LEVEL_W'(i + 1);
    end
    c.own        = own;
    c.level      = lv;
    c.shift      = SHIFT_W'(3 * lv);
    m19          = (19'd1 << c.shift) - 19'd1;
    c.mask       = m19[ADDR_W-1:0];
    c.deep_mask  = {~c.mask[ADDR_W-4:0], 3'b000};
    c.nhop_mask  = {c.mask[ADDR_W-4:0], 3'b111};
    c.parent     = own & (c.mask >> 3);
    up           = (lv != '0) ? (own >> (c.shift - SHIFT_W'(3))) : '0;
    c.ppipe      = up[PIPE_W-1:0];
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (cfg_we_i) begin
      own_q <= cfg_wdata_i;
    end
  end

  assign cfg_d = decode_own(own_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= decode_own('0);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

@@ rtl/core/otau_digit_stage.sv @@
// Stage two: digit checks, masking, pipe digit and radio pipe address.
module otau_digit_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otau_pkg::own_cfg_t  cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  otau_pkg::in_t       data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output otau_pkg::mid_t      data_o
);
  import otau_pkg::*;

  logic valid_q;
  mid_t mid_d, mid_q;

  always_comb begin
    logic [ADDR_W-1:0] up;
    logic [ADDR_W-1:0] sh_other;
    logic [3:0]        nib;
    for (int i = 0; i < DIGITS; i++) begin
      up         = data_i.other_address >> (3 * i);
      mid_d.bad[i] = (up != '0) && !(up[2:0] inside {[3'd1:3'd5]});
    end
    mid_d.masked           = data_i.other_address & cfg_i.mask;
    mid_d.high             = data_i.other_address & cfg_i.deep_mask;
    mid_d.next_hop         = data_i.other_address & cfg_i.nhop_mask;
    sh_other               = data_i.other_address >> cfg_i.shift;
    mid_d.pipe_of_address  = sh_other[PIPE_W-1:0];
    mid_d.address_for_pipe = (ADDR_W'(data_i.pipe) << cfg_i.shift) | cfg_i.own;
    mid_d.radio_pipe_address[7:0] = pipe_segment(data_i.pipe);
    for (int k = 0; k < 4; k++) begin
      nib = data_i.other_address[4*k +: 4];
      mid_d.radio_pipe_address[8*(k+1) +: 8] = {~nib, nib};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = mid_q;
endmodule

@@ rtl/core/otau_class_stage.sv @@
// Stage three: descendant and child compare, validity, result register.
module otau_class_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otau_pkg::own_cfg_t  cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  otau_pkg::mid_t      data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output otau_pkg::out_t      data_o
);
  import otau_pkg::*;

  logic valid_q;
  out_t res_d, res_q;

  always_comb begin
    res_d.address_valid      = ~|data_i.bad;
    res_d.is_descendant      = (data_i.masked == cfg_i.own);
    res_d.is_child           = res_d.is_descendant && (data_i.high == '0);
    res_d.next_hop           = data_i.next_hop;
    res_d.pipe_of_address    = data_i.pipe_of_address;
    res_d.address_for_pipe   = data_i.address_for_pipe;
    res_d.radio_pipe_address = data_i.radio_pipe_address;
    res_d.tree_level         = cfg_i.level;
    res_d.parent_address     = cfg_i.parent;
    res_d.uplink_pipe        = cfg_i.ppipe;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;
endmodule

@@ test/octal_tree_address_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench: random and corner-case address requests checked against a local route model.
module octal_tree_address_unit_test;
  import otau_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned CALM_TAIL       = 150;
  localparam int unsigned PRESSURE_AT     = 400;
  localparam int unsigned PRESSURE_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES   = 3;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned TIMEOUT_CYCLES  = 400000;
  localparam int unsigned NUM_SEGMENTS    = 6;
  localparam logic [8*NUM_SEGMENTS-1:0] SEGMENTS = 48'hc3a596695a3c;

  typedef struct {
    bit                write_own;
    logic [ADDR_W-1:0] own_value;
    in_t               item;
  } route_request_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  otau_stream_if #(.payload_t(in_t))  request_ch ();
  otau_stream_if #(.payload_t(out_t)) route_ch ();

  route_request_t    request_q[$];
  out_t              expected_routes[$];
  logic [ADDR_W-1:0] own_model = '0;
  int unsigned       accepted = 0;
  int unsigned       received = 0;
  int unsigned       own_writes = 0;
  int unsigned       mismatches = 0;
  int unsigned       settle = 0;
  int unsigned       send_gap = 0;
  int unsigned       ready_gap = 0;
  int unsigned       hold_left = 0;
  bit                pressure_done = 1'b0;
  bit                tail_calm = 1'b0;

  octal_tree_address_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (request_ch),
    .out_o       (route_ch)
  );

  function automatic out_t route_of(in_t req, logic [ADDR_W-1:0] own);
    out_t        r;
    int unsigned lv, sh, mask, deep_mask, o, p, w, t;
    logic [3:0]  nib;
    o = 32'(req.other_address);
    p = 32'(req.pipe);
    w = 32'(own);
    lv = 0;
    for (int i = 0; i < DIGITS; i++) begin
      if ((w >> (3 * i)) != 0) lv = i + 1;
    end
    sh = 3 * lv;
    mask = ((32'd1 << sh) - 1) & 32'hFFFF;
    r = '0;
    r.address_valid = 1'b1;
    for (t = o; t != 0; t = t >> 3) begin
      if ((t & 7) == 0 || (t & 7) > 5) r.address_valid = 1'b0;
    end
    r.is_descendant = ((o & mask) == w);
    deep_mask = ((~mask & 32'hFFFF) << 3) & 32'hFFFF;
    r.is_child = r.is_descendant && ((o & deep_mask) == 0);
    r.next_hop = ADDR_W'(o & (((mask << 3) | 7) & 32'hFFFF));
    r.pipe_of_address = PIPE_W'((o >> sh) & 7);
    r.address_for_pipe = ADDR_W'(((p << sh) | w) & 32'hFFFF);
    if (p < NUM_SEGMENTS) r.radio_pipe_address[7:0] = SEGMENTS[8*p +: 8];
    for (int k = 0; k < 4; k++) begin
      nib = 4'((o >> (4 * k)) & 15);
      r.radio_pipe_address[8*(k+1) +: 8] = {~nib, nib};
    end
    r.tree_level = LEVEL_W'(lv);
    r.parent_address = ADDR_W'(w & (mask >> 3));
    r.uplink_pipe = (lv > 0) ? PIPE_W'((w >> (sh - 3)) & 7) : '0;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] tree_address(int unsigned depth, bit well_formed);
    int unsigned a, d;
    a = 0;
    for (int i = 0; i < depth && i < DIGITS; i++) begin
      d = well_formed ? $urandom_range(1, 5) : $urandom_range(0, 7);
      a = a | (d << (3 * i));
    end
    return a[ADDR_W-1:0];
  endfunction

  task automatic compare_field(string name, logic [RPA_W-1:0] want, logic [RPA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_route(out_t want, out_t got);
    compare_field("address_valid", RPA_W'(want.address_valid), RPA_W'(got.address_valid));
    compare_field("is_descendant", RPA_W'(want.is_descendant), RPA_W'(got.is_descendant));
    compare_field("is_child", RPA_W'(want.is_child), RPA_W'(got.is_child));
    compare_field("next_hop", RPA_W'(want.next_hop), RPA_W'(got.next_hop));
    compare_field("pipe_of_address", RPA_W'(want.pipe_of_address),
                  RPA_W'(got.pipe_of_address));
    compare_field("address_for_pipe", RPA_W'(want.address_for_pipe),
                  RPA_W'(got.address_for_pipe));
    compare_field("radio_pipe_address", want.radio_pipe_address, got.radio_pipe_address);
    compare_field("tree_level", RPA_W'(want.tree_level), RPA_W'(got.tree_level));
    compare_field("parent_address", RPA_W'(want.parent_address),
                  RPA_W'(got.parent_address));
    compare_field("uplink_pipe", RPA_W'(want.uplink_pipe), RPA_W'(got.uplink_pipe));
  endtask

  task automatic queue_request(logic [ADDR_W-1:0] other, logic [PIPE_W-1:0] pipe);
    route_request_t e;
    e.write_own = 1'b0;
    e.own_value = '0;
    e.item.other_address = other;
    e.item.pipe = pipe;
    request_q.push_back(e);
  endtask

  task automatic queue_own_write(logic [ADDR_W-1:0] value);
    route_request_t e;
    e.write_own = 1'b1;
    e.own_value = value;
    e.item = '0;
    request_q.push_back(e);
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin : drive
    logic           next_valid;
    logic           next_we;
    in_t            next_payload;
    route_request_t head;
    bit             calm_now;
    if (rst_n) begin
      next_valid   = request_ch.valid;
      next_payload = request_ch.payload;
      next_we      = 1'b0;
      calm_now     = request_q.size() < CALM_TAIL;
      if (request_ch.valid && request_ch.ready) begin
        expected_routes.push_back(route_of(request_ch.payload, own_model));
        accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (settle > 0) begin
          settle--;
        end else if (request_q.size() > 0) begin
          if (request_q[0].write_own) begin
            // write only once every transfer has come back
            if (received == accepted) begin
              head = request_q.pop_front();
              next_we = 1'b1;
              cfg_wdata <= head.own_value;
              own_model = head.own_value;
              own_writes++;
              settle = SETTLE_CYCLES;
            end
          end else if (send_gap > 0) begin
            send_gap--;
          end else if (!calm_now && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 11);
          end else begin
            head = request_q.pop_front();
            next_valid = 1'b1;
            next_payload = head.item;
          end
        end
      end
      request_ch.valid   <= next_valid;
      request_ch.payload <= next_payload;
      cfg_we             <= next_we;
      tail_calm          <= calm_now;
    end
  end

  always @(posedge clk) begin : observe
    logic next_ready;
    out_t want;
    if (rst_n) begin
      if (route_ch.valid && route_ch.ready) begin
        if (expected_routes.size() == 0) begin
          $error("unexpected result transfer: %h", route_ch.payload);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          check_route(want, route_ch.payload);
        end
        received <= received + 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!pressure_done && received >= PRESSURE_AT) begin
        // hold the output long enough to back up into the input
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES - 1;
        next_ready = 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        next_ready = 1'b0;
      end else if (!tail_calm && $urandom_range(0, 4) == 0) begin
        ready_gap = $urandom_range(0, 11);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      route_ch.ready <= next_ready;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] own;
    int unsigned       depth, kind;
    bit                wf;
    logic [31:0]       ext;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    request_ch.valid   = 1'b0;
    request_ch.payload = '0;
    route_ch.ready     = 1'b0;

    // root node, field extremes, all pipes
    queue_own_write(16'h0000);
    queue_request(16'h0000, 3'd0);
    queue_request(16'hFFFF, 3'd7);
    queue_request(16'h14E5, 3'd5);
    queue_request(16'h9249, 3'd6);
    queue_request(16'h0007, 3'd1);
    queue_request(16'h8000, 3'd2);
    queue_request(16'h0040, 3'd3);
    queue_request(16'h5AD1, 3'd4);
    // full-depth own address
    queue_own_write(16'hFFFF);
    queue_request(16'hFFFF, 3'd7);
    queue_request(16'h0000, 3'd0);
    queue_request(16'h7FFF, 3'd3);
    queue_request(16'h0001, 3'd5);
    // level five, one-bit top digit
    queue_own_write(16'h14E5);
    queue_request(16'h14E5, 3'd0);
    queue_request(16'h94E5, 3'd1);
    queue_request(16'h14E5, 3'd7);
    queue_request(16'h94E5, 3'd6);
    queue_request(16'h34E5, 3'd2);
    queue_request(16'h0123, 3'd3);
    // level one
    queue_own_write(16'h0003);
    queue_request(16'h001B, 3'd2);
    queue_request(16'h02DB, 3'd4);
    queue_request(16'h0005, 3'd1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      depth = $urandom_range(0, DIGITS);
      own = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                        : tree_address(depth, 1'b1);
      queue_own_write(own);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        wf = $urandom_range(0, 7) != 0;
        if (kind <= 5) begin
          ext = 32'(tree_address($urandom_range(0, DIGITS - depth), wf)) << (3 * depth);
          queue_request(own | ext[ADDR_W-1:0], 3'($urandom_range(0, 7)));
        end else if (kind <= 7) begin
          ext = 32'(tree_address(1, wf)) << (3 * depth);
          queue_request(own | ext[ADDR_W-1:0], 3'($urandom_range(0, 7)));
        end else if (kind == 8) begin
          queue_request(16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)));
        end else begin
          queue_request(tree_address($urandom_range(0, DIGITS), wf),
                        3'($urandom_range(0, 7)));
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || request_ch.valid || expected_routes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d address transfers under %0d own-address settings (levels 0..6).",
             accepted, own_writes);
    $display("Pipes 0..7 and 16-bit corners included; output held off %0d cycles once.",
             PRESSURE_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
